[rtl/core/synth_voice_allocator_core_macros.svh]
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared concurrent assertion forms for the voice allocator checks.
// ----------------------------------------------------------------------------
`ifndef SYNTH_VOICE_ALLOCATOR_CORE_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, clocked on the rising edge, off during reset
`define SVA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/svalloc_pkg.sv]
// ----------------------------------------------------------------------------
// Voice allocator package
// Codes, constants and control structures shared by the allocator modules.
// ----------------------------------------------------------------------------
package svalloc_pkg;

  localparam int unsigned VOICES_DEF = 8;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2,
    OP_PREVIEW  = 2'd3
  } op_e;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_SILENCE = 1'b1
  } act_e;

  typedef enum logic [1:0] {
    BUS_SHORT = 2'd0,
    BUS_DRY   = 2'd1,
    BUS_LONG  = 2'd2
  } bus_e;

  localparam logic [6:0] VEL_MAX     = 7'd127;
  localparam logic [7:0] ACCENT_ADD  = 8'd24;
  localparam logic [6:0] SEND_HALL   = 7'd64;
  localparam logic [6:0] PREVIEW_VEL = 7'd110;
  localparam logic [7:0] TRACK_PREV  = 8'hFE;

  // one voice table entry held in RAM
  typedef struct packed {
    logic [7:0]  track;
    logic [6:0]  note;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the beat, clear walk state
    logic scan;        // streamed read / age compare step
    logic skip;        // note off: no match, move on
    logic take;        // note off: release matched voice
    logic flush;       // note off: send held result as last
    logic push_steal;  // silence the stolen voice
    logic push_start;  // start the chosen voice and update table
    logic all_push;    // all off: silence current voice
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic steal;
    logic match;
    logic pend_v;
    logic out_free;
    logic cnt_last;
  } sts_t;

endpackage

[rtl/core/svalloc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module svalloc_ram #(
  parameter int unsigned WIDTH = svalloc_pkg::ENTRY_W,
  parameter int unsigned DEPTH = svalloc_pkg::VOICES_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/svalloc_ctrl.sv]
// ----------------------------------------------------------------------------
// Voice allocator controller
// Sequences the voice walk for each operation and the result beats.
// ----------------------------------------------------------------------------
module svalloc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         operation_i,
  input  logic               muted_i,
  input  svalloc_pkg::sts_t  sts_i,
  output svalloc_pkg::cmd_t  cmd_o,
  output logic               in_stall_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STEAL,
    ST_START,
    ST_OFF_RD,
    ST_OFF_CK,
    ST_OFF_FL,
    ST_ALL
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;
  svalloc_pkg::op_e op;

  assign op = svalloc_pkg::op_e'(operation_i);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (op)
            svalloc_pkg::OP_NOTE_ON: state_d = muted_i ? ST_IDLE : ST_SCAN;
            svalloc_pkg::OP_PREVIEW: state_d = ST_SCAN;
            svalloc_pkg::OP_NOTE_OFF: state_d = ST_OFF_RD;
            svalloc_pkg::OP_ALL_OFF: state_d = ST_ALL;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.steal ? ST_STEAL : ST_START;
        end
      end
      ST_STEAL: begin
        if (sts_i.out_free) begin
          cmd_o.push_steal = 1'b1;
          state_d          = ST_START;
        end
      end
      ST_START: begin
        if (sts_i.out_free) begin
          cmd_o.push_start = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_OFF_RD: begin
        // RAM read of the current voice is in flight
        state_d = ST_OFF_CK;
      end
      ST_OFF_CK: begin
        if (!sts_i.match) begin
          cmd_o.skip = 1'b1;
          state_d    = sts_i.cnt_last ? ST_OFF_FL : ST_OFF_RD;
        end else if (!sts_i.pend_v || sts_i.out_free) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.cnt_last ? ST_OFF_FL : ST_OFF_RD;
        end
      end
      ST_OFF_FL: begin
        if (!sts_i.pend_v) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_ALL: begin
        if (sts_i.out_free) begin
          cmd_o.all_push = 1'b1;
          if (sts_i.cnt_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != ST_IDLE);
    end
  end

  assign in_stall_o = stall_q;

endmodule

[rtl/core/svalloc_dp.sv]
// ----------------------------------------------------------------------------
// Voice allocator datapath
// Voice table, walk counter, age trackers, velocity scaling, result register.
// ----------------------------------------------------------------------------
module svalloc_dp #(
  parameter int unsigned VOICES = svalloc_pkg::VOICES_DEF,
  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  svalloc_pkg::cmd_t cmd_i,
  output svalloc_pkg::sts_t sts_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        track_i,
  input  logic [6:0]        note_i,
  input  logic [6:0]        velocity_i,
  input  logic              accent_i,
  input  logic [6:0]        track_volume_i,
  input  logic [6:0]        reverb_send_i,
  input  logic [31:0]       now_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              action_o,
  output logic [VW-1:0]     voice_o,
  output logic [6:0]        out_velocity_o,
  output logic [1:0]        bus_o,
  output logic [6:0]        played_note_o,
  output logic              last_o
);

  localparam int unsigned CW = $clog2(VOICES + 1);

  // latched beat
  svalloc_pkg::op_e op_q;
  logic [7:0]       trk_q;
  logic [6:0]       note_q, vel_q, vol_q, send_q;
  logic             acc_q;
  logic [31:0]      now_q;

  logic             fx_q;

  // walk state
  logic [CW-1:0]     cnt_q;
  logic              rv_q;
  logic [VW-1:0]     rd_idx_q;
  logic [VOICES-1:0] act_q, rel_q;

  // age trackers
  logic          free_v_q, rel_v_q, act_v_q;
  logic [VW-1:0] free_idx_q, rel_idx_q, act_idx_q;
  logic [31:0]   rel_st_q, act_st_q;

  // held note-off result
  logic          pend_v_q;
  logic [VW-1:0] pend_idx_q;

  // velocity pipeline
  logic [13:0] prod_q;
  logic [6:0]  quo_q;

  // result register
  logic          out_v_q, act_out_q, last_q;
  logic [VW-1:0] voice_q;
  logic [6:0]    ovel_q, pnote_q;
  logic [1:0]    bus_q;

  // RAM
  svalloc_pkg::entry_t rdata, wdata;
  logic                we;
  logic [VW-1:0]       waddr, cnt_idx, sel_idx;

  logic       out_free, done_walk, cnt_last, match;
  logic       rd_act, rd_rel;
  logic [7:0] vacc;
  logic [6:0] vsat, q0, vstart;
  logic [7:0] rem;
  logic [1:0] bus_sel;

  assign cnt_idx   = cnt_q[VW-1:0];
  assign done_walk = (cnt_q == CW'(VOICES));
  assign cnt_last  = (cnt_q == CW'(VOICES - 1));
  assign out_free  = !out_v_q || !out_stall_i;
  assign rd_act    = act_q[rd_idx_q];
  assign rd_rel    = rel_q[rd_idx_q];
  assign match     = act_q[cnt_idx] && (rdata.track == trk_q) && (rdata.note == note_q);
  assign sel_idx   = free_v_q ? free_idx_q : (rel_v_q ? rel_idx_q : act_idx_q);

  // velocity: accent, clamp, then floor(v * vol / 127) as shift plus one correction
  assign vacc = {1'b0, vel_q} + (acc_q ? svalloc_pkg::ACCENT_ADD : 8'd0);
  assign vsat = (vacc > {1'b0, svalloc_pkg::VEL_MAX}) ? svalloc_pkg::VEL_MAX : vacc[6:0];
  assign q0   = prod_q[13:7];
  assign rem  = {1'b0, prod_q[6:0]} + {1'b0, q0};

  assign vstart = (op_q == svalloc_pkg::OP_PREVIEW) ? svalloc_pkg::PREVIEW_VEL : quo_q;

  always_comb begin
    if (!fx_q) begin
      bus_sel = svalloc_pkg::BUS_SHORT;
    end else if (send_q == 7'd0) begin
      bus_sel = svalloc_pkg::BUS_DRY;
    end else if (send_q < svalloc_pkg::SEND_HALL) begin
      bus_sel = svalloc_pkg::BUS_SHORT;
    end else begin
      bus_sel = svalloc_pkg::BUS_LONG;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_idx;
    wdata = rdata;
    if (cmd_i.take) begin
      we          = 1'b1;
      wdata.stamp = now_q;
    end else if (cmd_i.push_start) begin
      we          = 1'b1;
      waddr       = sel_idx;
      wdata.track = (op_q == svalloc_pkg::OP_PREVIEW) ? svalloc_pkg::TRACK_PREV : trk_q;
      wdata.note  = note_q;
      wdata.stamp = now_q;
    end
  end

  svalloc_ram #(
    .WIDTH (svalloc_pkg::ENTRY_W),
    .DEPTH (VOICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (cnt_idx),
    .rdata_o (rdata)
  );

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= svalloc_pkg::op_e'(operation_i);
      trk_q  <= track_i;
      note_q <= note_i;
      vel_q  <= velocity_i;
      acc_q  <= accent_i;
      vol_q  <= track_volume_i;
      send_q <= reverb_send_i;
      now_q  <= now_ms_i;
    end
    prod_q <= {7'd0, vsat} * {7'd0, vol_q};
    quo_q  <= (rem >= {1'b0, svalloc_pkg::VEL_MAX}) ? q0 + 7'd1 : q0;

    if (cmd_i.scan && rv_q) begin
      if (!free_v_q && !rd_act && !rd_rel) begin
        free_idx_q <= rd_idx_q;
      end
      if (rd_rel && (!rel_v_q || rdata.stamp < rel_st_q)) begin
        rel_idx_q <= rd_idx_q;
        rel_st_q  <= rdata.stamp;
      end
      if (rd_act && (!act_v_q || rdata.stamp < act_st_q)) begin
        act_idx_q <= rd_idx_q;
        act_st_q  <= rdata.stamp;
      end
    end
    if (cmd_i.load) begin
      act_idx_q <= '0;
    end
    if (cmd_i.scan && !done_walk) begin
      rd_idx_q <= cnt_idx;
    end
    if (cmd_i.take) begin
      pend_idx_q <= cnt_idx;
    end

    if (cmd_i.push_steal || cmd_i.all_push || cmd_i.flush ||
        (cmd_i.take && pend_v_q)) begin
      act_out_q <= svalloc_pkg::ACT_SILENCE;
      ovel_q    <= 7'd0;
      bus_q     <= svalloc_pkg::BUS_SHORT;
      pnote_q   <= 7'd0;
    end
    if (cmd_i.push_steal) begin
      voice_q <= sel_idx;
      last_q  <= 1'b0;
    end
    if (cmd_i.all_push) begin
      voice_q <= cnt_idx;
      last_q  <= cnt_last;
    end
    if (cmd_i.flush) begin
      voice_q <= pend_idx_q;
      last_q  <= 1'b1;
    end
    if (cmd_i.take && pend_v_q) begin
      voice_q <= pend_idx_q;
      last_q  <= 1'b0;
    end
    if (cmd_i.push_start) begin
      act_out_q <= svalloc_pkg::ACT_START;
      voice_q   <= sel_idx;
      ovel_q    <= vstart;
      bus_q     <= bus_sel;
      pnote_q   <= note_q;
      last_q    <= 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q     <= 1'b1;
      cnt_q    <= '0;
      rv_q     <= 1'b0;
      act_q    <= '0;
      rel_q    <= '0;
      free_v_q <= 1'b0;
      rel_v_q  <= 1'b0;
      act_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fx_q <= cfg_wdata_i;
      end

      if (cmd_i.load) begin
        cnt_q    <= '0;
        rv_q     <= 1'b0;
        free_v_q <= 1'b0;
        rel_v_q  <= 1'b0;
        act_v_q  <= 1'b0;
        pend_v_q <= 1'b0;
      end

      if (cmd_i.scan) begin
        rv_q <= !done_walk;
        if (!done_walk) begin
          cnt_q <= cnt_q + CW'(1);
        end
        if (rv_q) begin
          if (!rd_act && !rd_rel) free_v_q <= 1'b1;
          if (rd_rel) rel_v_q <= 1'b1;
          if (rd_act) act_v_q <= 1'b1;
        end
      end

      if (cmd_i.skip || cmd_i.all_push) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.take) begin
        cnt_q          <= cnt_q + CW'(1);
        pend_v_q       <= 1'b1;
        act_q[cnt_idx] <= 1'b0;
        rel_q[cnt_idx] <= 1'b1;
      end
      if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if (cmd_i.push_start) begin
        act_q[sel_idx] <= (op_q != svalloc_pkg::OP_PREVIEW);
        rel_q[sel_idx] <= (op_q == svalloc_pkg::OP_PREVIEW);
      end
      if (cmd_i.all_push && cnt_last) begin
        act_q <= '0;
        rel_q <= '0;
      end

      if (cmd_i.push_steal || cmd_i.push_start || cmd_i.all_push || cmd_i.flush ||
          (cmd_i.take && pend_v_q)) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign sts_o.scan_done = done_walk && !rv_q;
  assign sts_o.steal     = !free_v_q && !rel_v_q;
  assign sts_o.match     = match;
  assign sts_o.pend_v    = pend_v_q;
  assign sts_o.out_free  = out_free;
  assign sts_o.cnt_last  = cnt_last;

  assign out_valid_o    = out_v_q;
  assign action_o       = act_out_q;
  assign voice_o        = voice_q;
  assign out_velocity_o = ovel_q;
  assign bus_o          = bus_q;
  assign played_note_o  = pnote_q;
  assign last_o         = last_q;

endmodule

[rtl/core/synth_voice_allocator_core.sv]
// ----------------------------------------------------------------------------
// Polyphonic voice allocator
// Voice table with free / oldest-released / oldest-active selection.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------
//  in       | slave     | in_valid_i / in_stall_o   | operation .. now_ms
//  out      | master    | out_valid_o / out_stall_i | action .. last
//  cfg      | slave     | cfg_we_i                  | cfg_wdata_i (fx_enable)
//
// Note on / preview: the table is walked through the one RAM read port, then the
// start beat is sent, preceded by a silence beat when a voice is stolen. Note off:
// each voice is read and then checked; the held release goes out as the last beat.
// All off: one silence beat per voice. Muted note on: accepted with no walk.
// Reset clears the voice flags at once; no clearing pass.
// A stalled result beat holds in the output register; the next beat waits for it.
// ----------------------------------------------------------------------------
module synth_voice_allocator_core #(
  parameter int unsigned VOICES = svalloc_pkg::VOICES_DEF,
  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    operation_i,
  input  logic [7:0]    track_i,
  input  logic [6:0]    note_i,
  input  logic [6:0]    velocity_i,
  input  logic          accent_i,
  input  logic          muted_i,
  input  logic [6:0]    track_volume_i,
  input  logic [6:0]    reverb_send_i,
  input  logic [31:0]   now_ms_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          action_o,
  output logic [VW-1:0] voice_o,
  output logic [6:0]    out_velocity_o,
  output logic [1:0]    bus_o,
  output logic [6:0]    played_note_o,
  output logic          last_o
);

  svalloc_pkg::cmd_t cmd;
  svalloc_pkg::sts_t sts;

  svalloc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .muted_i     (muted_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  svalloc_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .track_i        (track_i),
    .note_i         (note_i),
    .velocity_i     (velocity_i),
    .accent_i       (accent_i),
    .track_volume_i (track_volume_i),
    .reverb_send_i  (reverb_send_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .voice_o        (voice_o),
    .out_velocity_o (out_velocity_o),
    .bus_o          (bus_o),
    .played_note_o  (played_note_o),
    .last_o         (last_o)
  );

endmodule

[rtl/core/svalloc_chk.sv]
// ----------------------------------------------------------------------------
// Voice allocator port checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "synth_voice_allocator_core_macros.svh"

module svalloc_chk #(
  parameter int unsigned VOICES = svalloc_pkg::VOICES_DEF,
  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic [1:0]    operation_i,
  input logic          muted_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input logic          action_o,
  input logic [VW-1:0] voice_o,
  input logic [6:0]    out_velocity_o,
  input logic [1:0]    bus_o,
  input logic [6:0]    played_note_o,
  input logic          last_o
);

  logic           in_beat_work, out_hold, out_silence, out_start, out_quiet;
  logic [VW+18:0] out_beat;

  // every beat except a muted note on keeps the block busy next cycle
  assign in_beat_work = in_valid_i && !in_stall_o &&
                        !((operation_i == svalloc_pkg::OP_NOTE_ON) && muted_i);
  assign out_hold     = out_valid_o && out_stall_i;
  assign out_silence  = out_valid_o && (action_o == svalloc_pkg::ACT_SILENCE);
  assign out_start    = out_valid_o && (action_o == svalloc_pkg::ACT_START);
  assign out_quiet    = (out_velocity_o == 7'd0) && (bus_o == svalloc_pkg::BUS_SHORT) &&
                        (played_note_o == 7'd0);
  assign out_beat     = {out_valid_o, action_o, voice_o, out_velocity_o, bus_o,
                         played_note_o, last_o};

  `SVA_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_beat_work, in_stall_o, "idle after beat")
  `SVA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold, $stable(out_beat), "stalled beat changed")
  `SVA_ASSERT_NOW(a_silence_zero, clk_i, rst_ni, out_silence, out_quiet, "silence payload set")
  `SVA_ASSERT_NOW(a_start_last, clk_i, rst_ni, out_start, last_o, "start beat not last")

endmodule

bind synth_voice_allocator_core svalloc_chk #(
  .VOICES (VOICES)
) u_svalloc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .operation_i    (operation_i),
  .muted_i        (muted_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .action_o       (action_o),
  .voice_o        (voice_o),
  .out_velocity_o (out_velocity_o),
  .bus_o          (bus_o),
  .played_note_o  (played_note_o),
  .last_o         (last_o)
);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives note on, note off, all off and preview beats into the allocator and
// checks every voice action against a local copy of the voice table, across
// several idle and stall mixes and both settings of the effects bus enable.
// ----------------------------------------------------------------------------
module tb;

  localparam int          NV         = svalloc_pkg::VOICES_DEF;
  localparam logic [7:0]  TRACK_NONE = 8'hFF;
  localparam int          LIMIT      = 200000;
  localparam int          SETTLE     = 40;

  typedef struct packed {
    svalloc_pkg::op_e op;
    logic [7:0]       track;
    logic [6:0]       note;
    logic [6:0]       velocity;
    logic             accent;
    logic             muted;
    logic [6:0]       volume;
    logic [6:0]       send;
    logic [31:0]      now;
  } voice_evt_t;

  typedef struct packed {
    svalloc_pkg::act_e action;
    logic [2:0]        voice;
    logic [6:0]        vel;
    svalloc_pkg::bus_e bus;
    logic [6:0]        note;
    logic              last;
  } voice_act_t;

  // voice table copy and the queue of voice actions still owed by the block
  class voice_alloc_sb;
    logic        fx_en;
    logic        active[NV];
    logic        released[NV];
    logic [7:0]  track[NV];
    logic [6:0]  note[NV];
    logic [31:0] stamp[NV];
    voice_act_t  due_actions[$];
    int          errors;

    function new();
      fx_en  = 1'b1;
      errors = 0;
      for (int i = 0; i < NV; i++) begin
        active[i]   = 1'b0;
        released[i] = 1'b0;
        track[i]    = TRACK_NONE;
        note[i]     = '0;
        stamp[i]    = '0;
      end
    endfunction

    function void push_action(svalloc_pkg::act_e k, int v, int vel, svalloc_pkg::bus_e b,
                              int n);
      voice_act_t a;
      a.action = k;
      a.voice  = 3'(v);
      a.vel    = 7'(vel);
      a.bus    = b;
      a.note   = 7'(n);
      a.last   = 1'b0;
      due_actions.push_back(a);
    endfunction

    function string act_str(voice_act_t a);
      return $sformatf("act=%0d voice=%0d vel=%0d bus=%0d note=%0d last=%0d",
                       a.action, a.voice, a.vel, a.bus, a.note, a.last);
    endfunction

    function void take_event(voice_evt_t e);
      int                slot, old_rel, old_act, level, first;
      svalloc_pkg::bus_e b;
      voice_act_t        a;
      first = due_actions.size();
      if (e.op == svalloc_pkg::OP_NOTE_ON || e.op == svalloc_pkg::OP_PREVIEW) begin
        if (e.op == svalloc_pkg::OP_NOTE_ON && e.muted) return;
        slot    = -1;
        old_rel = -1;
        old_act = -1;
        for (int i = 0; i < NV; i++) begin
          if (slot < 0) begin
            if (!active[i] && !released[i]) slot = i;
            else begin
              if (released[i] && (old_rel < 0 || stamp[i] < stamp[old_rel])) old_rel = i;
              if (active[i] && (old_act < 0 || stamp[i] < stamp[old_act])) old_act = i;
            end
          end
        end
        if (slot < 0 && old_rel >= 0) slot = old_rel;
        if (slot < 0) begin
          // every voice busy: silence the oldest active one first
          slot = old_act;
          push_action(svalloc_pkg::ACT_SILENCE, slot, 0, svalloc_pkg::BUS_SHORT, 0);
        end
        if (e.op == svalloc_pkg::OP_NOTE_ON) begin
          level = int'(e.velocity) + (e.accent ? int'(svalloc_pkg::ACCENT_ADD) : 0);
          if (level > int'(svalloc_pkg::VEL_MAX)) level = int'(svalloc_pkg::VEL_MAX);
          level = level * int'(e.volume) / int'(svalloc_pkg::VEL_MAX);
          active[slot]   = 1'b1;
          released[slot] = 1'b0;
          track[slot]    = e.track;
        end else begin
          level          = int'(svalloc_pkg::PREVIEW_VEL);
          active[slot]   = 1'b0;
          released[slot] = 1'b1;
          track[slot]    = svalloc_pkg::TRACK_PREV;
        end
        note[slot]  = e.note;
        stamp[slot] = e.now;
        if (!fx_en) b = svalloc_pkg::BUS_SHORT;
        else if (e.send == 7'd0) b = svalloc_pkg::BUS_DRY;
        else if (e.send < svalloc_pkg::SEND_HALL) b = svalloc_pkg::BUS_SHORT;
        else b = svalloc_pkg::BUS_LONG;
        push_action(svalloc_pkg::ACT_START, slot, level, b, e.note);
      end else if (e.op == svalloc_pkg::OP_NOTE_OFF) begin
        for (int i = 0; i < NV; i++) begin
          if (active[i] && track[i] == e.track && note[i] == e.note) begin
            push_action(svalloc_pkg::ACT_SILENCE, i, 0, svalloc_pkg::BUS_SHORT, 0);
            active[i]   = 1'b0;
            released[i] = 1'b1;
            stamp[i]    = e.now;
          end
        end
      end else begin
        for (int i = 0; i < NV; i++) begin
          push_action(svalloc_pkg::ACT_SILENCE, i, 0, svalloc_pkg::BUS_SHORT, 0);
          active[i]   = 1'b0;
          released[i] = 1'b0;
          track[i]    = TRACK_NONE;
        end
      end
      if (due_actions.size() > first) begin
        a = due_actions.pop_back();
        a.last = 1'b1;
        due_actions.push_back(a);
      end
    endfunction

    function void check_action(voice_act_t got);
      voice_act_t want;
      if (due_actions.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected voice action: %s", act_str(got));
        return;
      end
      want = due_actions.pop_front();
      if (got.action !== want.action || got.voice !== want.voice ||
          got.vel !== want.vel || got.bus !== want.bus ||
          got.note !== want.note || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("voice action mismatch: expected %s, got %s", act_str(want), act_str(got));
      end
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_wdata_i    = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i    = '0;
  logic [7:0]  track_i        = '0;
  logic [6:0]  note_i         = '0;
  logic [6:0]  velocity_i     = '0;
  logic        accent_i       = 1'b0;
  logic        muted_i        = 1'b0;
  logic [6:0]  track_volume_i = '0;
  logic [6:0]  reverb_send_i  = '0;
  logic [31:0] now_ms_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        action_o;
  logic [2:0]  voice_o;
  logic [6:0]  out_velocity_o;
  logic [1:0]  bus_o;
  logic [6:0]  played_note_o;
  logic        last_o;

  voice_alloc_sb sb = new();
  int            gap_pct   = 0;
  int            stall_pct = 0;
  int            cycles    = 0;
  logic [31:0]   clock_ms  = 32'h100;

  synth_voice_allocator_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .track_i        (track_i),
    .note_i         (note_i),
    .velocity_i     (velocity_i),
    .accent_i       (accent_i),
    .muted_i        (muted_i),
    .track_volume_i (track_volume_i),
    .reverb_send_i  (reverb_send_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .voice_o        (voice_o),
    .out_velocity_o (out_velocity_o),
    .bus_o          (bus_o),
    .played_note_o  (played_note_o),
    .last_o         (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("synth_voice_allocator_core test failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    voice_act_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.action = svalloc_pkg::act_e'(action_o);
      got.voice  = voice_o;
      got.vel    = out_velocity_o;
      got.bus    = svalloc_pkg::bus_e'(bus_o);
      got.note   = played_note_o;
      got.last   = last_o;
      sb.check_action(got);
    end
  end

  function automatic voice_evt_t mk(svalloc_pkg::op_e op, int trk, int nt, int vel, bit acc,
                                    bit mute, int vol, int snd, logic [31:0] now);
    voice_evt_t e;
    e.op       = op;
    e.track    = 8'(trk);
    e.note     = 7'(nt);
    e.velocity = 7'(vel);
    e.accent   = acc;
    e.muted    = mute;
    e.volume   = 7'(vol);
    e.send     = 7'(snd);
    e.now      = now;
    return e;
  endfunction

  function automatic int edgy7();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 127 : 0;
    return $urandom_range(0, 127);
  endfunction

  function automatic voice_evt_t random_event();
    voice_evt_t e;
    int         pick;
    int         hits[$];
    pick = $urandom_range(0, 99);
    clock_ms += 32'($urandom_range(0, 40));
    if ($urandom_range(0, 29) == 0) clock_ms = $urandom();
    e.now      = clock_ms;
    e.track    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 253))
                                             : 8'($urandom_range(0, 5));
    e.note     = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(60, 67));
    e.velocity = 7'($urandom_range(0, 127));
    e.accent   = 1'($urandom_range(0, 1));
    e.muted    = ($urandom_range(0, 9) == 0);
    e.volume   = 7'(edgy7());
    e.send     = 7'(edgy7());
    if (pick < 45) e.op = svalloc_pkg::OP_NOTE_ON;
    else if (pick < 75) begin
      e.op = svalloc_pkg::OP_NOTE_OFF;
      for (int i = 0; i < NV; i++) if (sb.active[i]) hits.push_back(i);
      // mostly aim at a sounding voice so releases actually happen
      if (hits.size() > 0 && $urandom_range(0, 3) != 0) begin
        pick    = hits[$urandom_range(0, hits.size() - 1)];
        e.track = sb.track[pick];
        e.note  = sb.note[pick];
      end
    end else if (pick < 90) e.op = svalloc_pkg::OP_PREVIEW;
    else if (pick < 94) e.op = svalloc_pkg::OP_ALL_OFF;
    else begin
      e.op    = svalloc_pkg::OP_NOTE_ON;
      e.track = 8'($urandom_range(0, 253));
      e.note  = 7'($urandom_range(0, 127));
    end
    return e;
  endfunction

  // called at a falling edge; leaves valid high after the beat is taken
  task automatic send_beat(input voice_evt_t e);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i    <= e.op;
    track_i        <= e.track;
    note_i         <= e.note;
    velocity_i     <= e.velocity;
    accent_i       <= e.accent;
    muted_i        <= e.muted;
    track_volume_i <= e.volume;
    reverb_send_i  <= e.send;
    now_ms_i       <= e.now;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_event(e);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.due_actions.size() != 0);
  endtask

  // note off with no match leaves no trace, so give the walk time to finish
  task automatic set_fx(input logic v);
    drain();
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.fx_en = v;
  endtask

  task automatic run_phase(input int gp, input int sp, input int n, input bit hold);
    gap_pct   = gp;
    stall_pct = sp;
    for (int k = 0; k < n; k++) begin
      if (hold && k == n / 2) drain();
      send_beat(random_event());
    end
  endtask

  initial begin
    voice_evt_t opening[$];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_fx(1'b1);

    // fill the table; stamps 0 and all-ones, velocity and volume extremes
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,    0,   0,   0, 0, 0, 127,   0, 32'h10));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,  253, 127, 127, 0, 0, 127, 127,
                         32'hFFFF_FFFF));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,    1,  60, 110, 1, 0, 127,  63, 32'h20));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,    2,  61, 127, 1, 0,  64,  64, 32'h30));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,    3,  62, 100, 0, 0,   0,   1, 32'h40));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,    4,  63,   1, 1, 0, 100,  32, 32'h0));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,    5,  64,  85, 0, 0,  85, 100, 32'h50));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,    6,  65,  42, 1, 0, 127, 127, 32'h0));
    // muted, then two steals with a tie on the oldest stamp
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,    7,  66,  90, 0, 1, 127,  10, 32'h60));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,    7,  66,  90, 0, 0, 127,  10, 32'h60));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,    8,  67,  50, 1, 0,  99,  70, 32'h70));
    // release: no match, then two matches; next note on takes the older one
    opening.push_back(mk(svalloc_pkg::OP_NOTE_OFF,   9,  99,  20, 1, 1,  50,  50, 32'h75));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_OFF, 253, 127,   0, 0, 0,   0,   0,
                         32'hFFFF_FFFE));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_OFF,   1,  60,   0, 0, 0,   0,   0, 32'h80));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,   10,  70,  64, 0, 0, 127,  64, 32'h90));
    opening.push_back(mk(svalloc_pkg::OP_PREVIEW,   11,  71,   5, 1, 1,   0,  64, 32'hA0));
    // same note twice, one note off releases both
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,   12,  72,  77, 0, 0, 127,  20, 32'hB0));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_ON,   12,  72,  33, 1, 0, 127,  20, 32'hC0));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_OFF,  12,  72,   0, 0, 0,   0,   0, 32'hD0));
    opening.push_back(mk(svalloc_pkg::OP_ALL_OFF,    0,   0,   0, 0, 0,   0,   0, 32'hE0));
    opening.push_back(mk(svalloc_pkg::OP_PREVIEW,    0,   0,   0, 0, 0,   0,   0, 32'h0));
    opening.push_back(mk(svalloc_pkg::OP_NOTE_OFF, 254,   0,   0, 0, 0,   0,   0, 32'hF0));
    opening.push_back(mk(svalloc_pkg::OP_ALL_OFF,  255, 127, 127, 1, 1, 127, 127,
                         32'hFFFF_FFFF));
    gap_pct   = 16;
    stall_pct = 16;
    foreach (opening[k]) send_beat(opening[k]);

    set_fx(1'b0);
    run_phase(0, 0, 64, 1'b0);
    set_fx(1'b1);
    run_phase(50, 0, 64, 1'b1);
    set_fx(1'b0);
    run_phase(0, 50, 64, 1'b0);
    set_fx(1'b1);
    run_phase(16, 16, 64, 1'b0);

    drain();
    repeat (SETTLE) @(negedge clk_i);
    if (sb.errors == 0 && sb.due_actions.size() == 0) begin
      $display("synth_voice_allocator_core test passed");
    end else begin
      $display("synth_voice_allocator_core test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/svalloc_pkg.sv
rtl/core/svalloc_ram.sv
rtl/core/svalloc_ctrl.sv
rtl/core/svalloc_dp.sv
rtl/core/synth_voice_allocator_core.sv
rtl/core/svalloc_chk.sv
dv/tb.sv
